// File: hw/rtl/sfbm_pkg.sv
// Shared types and constants for the flash bank mapper.
// No dependencies; imported by every module of the block.
package sfbm_pkg;

   localparam int NUM_PAGES   = 4;
   localparam int PAGE_W      = $clog2(NUM_PAGES);
   localparam int BANK_W      = 8;
   localparam int OFFSET_W    = 13;                 // 8 KB page
   localparam int FLASH_ADDR_W = BANK_W + OFFSET_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // bus operation codes
   typedef enum logic [1:0] {
      OP_MEM_READ  = 2'd0,
      OP_MEM_WRITE = 2'd1,
      OP_IO_READ   = 2'd2,
      OP_IO_WRITE  = 2'd3
   } op_type;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_BLOCK_COUNT_LOG2 = 2'd0;
   localparam logic [1:0] REG_HAS_SCC          = 2'd1;
   localparam logic [1:0] REG_HAS_PSG          = 2'd2;

   // I/O ports
   localparam logic [7:0] PORT_PSG_LATCH = 8'h10;
   localparam logic [7:0] PORT_PSG_WRITE = 8'h11;
   localparam logic [7:0] PORT_PSG_READ  = 8'h12;

   // address decode keys, on address bits 15:11
   localparam logic [4:0] SCC_WIN_KEY    = 5'b10011;  // 0x9800-0x9FFF
   localparam logic [4:0] SCC_ENABLE_KEY = 5'b10010;  // 0x9000-0x97FF
   localparam logic [1:0] BANK_LOAD_KEY  = 2'b10;     // bits 12:11
   localparam logic [5:0] SCC_ON_PATTERN = 6'h3F;

   localparam logic [3:0] BLOCK_LOG2_MAX   = 4'd8;
   localparam logic [3:0] BLOCK_LOG2_RESET = 4'd6;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic                    flash_access;
      logic [FLASH_ADDR_W-1:0] flash_address;
      logic                    scc_access;
      logic [7:0]              scc_register;
      logic                    psg_access;
      logic [3:0]              psg_register;
      logic                    is_write;
      logic [7:0]              write_data;
      logic                    unmapped_read;
   } rsp_type;

   typedef struct packed {
      logic [3:0] block_count_log2;
      logic       has_scc;
      logic       has_psg;
   } cfg_type;

endpackage

// File: hw/rtl/sfbm_csr.sv
// Configuration registers of the flash bank mapper on an APB-style port.
// Depends on sfbm_pkg.
module sfbm_csr import sfbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_BLOCK_COUNT_LOG2: cfg_in.block_count_log2 = pwdata[3:0];
            REG_HAS_SCC:          cfg_in.has_scc          = pwdata[0];
            REG_HAS_PSG:          cfg_in.has_psg          = pwdata[0];
            default:              cfg_in                  = cfg_ff;  // no register
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_BLOCK_COUNT_LOG2: prdata[3:0] = cfg_ff.block_count_log2;
         REG_HAS_SCC:          prdata[0]   = cfg_ff.has_scc;
         REG_HAS_PSG:          prdata[0]   = cfg_ff.has_psg;
         default:              prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_count_log2 <= BLOCK_LOG2_RESET;
         cfg_ff.has_scc          <= 1'b1;
         cfg_ff.has_psg          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/sfbm_core.sv
// Address decode and mapper state (bank registers, SCC enable, PSG latch).
// Depends on sfbm_pkg. State updates when the held item moves to the output.
module sfbm_core import sfbm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   logic [BANK_W-1:0] bank_ff [NUM_PAGES];
   logic [BANK_W-1:0] bank_in [NUM_PAGES];
   logic              scc_en_ff, scc_en_in;
   logic [3:0]        psg_latch_ff, psg_latch_in;

   logic [15:0]       addr;
   logic [7:0]        port;
   logic              in_win, scc_win;
   logic [PAGE_W-1:0] page;
   logic [3:0]        log2_sat;
   logic [BANK_W:0]   mask_wide;
   logic [BANK_W-1:0] mask;
   logic [FLASH_ADDR_W-1:0] faddr;

   assign addr     = item.address;
   assign port     = addr[7:0];
   assign in_win   = (addr[15:14] == 2'b01) || (addr[15:14] == 2'b10);
   assign scc_win  = scc_en_ff & cfg.has_scc & (addr[15:11] == SCC_WIN_KEY);
   // page 0 starts at 0x4000
   assign page     = PAGE_W'(addr[15:13] - 3'd2);
   assign log2_sat = (cfg.block_count_log2 > BLOCK_LOG2_MAX) ? BLOCK_LOG2_MAX
                                                             : cfg.block_count_log2;
   assign mask_wide = ((BANK_W+1)'(1) << log2_sat) - (BANK_W+1)'(1);
   assign mask      = mask_wide[BANK_W-1:0];
   assign faddr     = {bank_ff[page], addr[OFFSET_W-1:0]};

   always_comb begin
      result       = '0;
      bank_in      = bank_ff;
      scc_en_in    = scc_en_ff;
      psg_latch_in = psg_latch_ff;
      unique case (op_type'(item.operation))
         OP_MEM_READ: begin
            priority if (scc_win) begin
               result.scc_access   = 1'b1;
               result.scc_register = port;
            end else if (in_win) begin
               result.flash_access  = 1'b1;
               result.flash_address = faddr;
            end else begin
               result.unmapped_read = 1'b1;
            end
         end
         OP_MEM_WRITE: begin
            // SCC window writes also go to flash, at the old bank
            if (scc_win) begin
               result.scc_access   = 1'b1;
               result.scc_register = port;
               result.is_write     = 1'b1;
               result.write_data   = item.value;
            end
            if (in_win) begin
               result.flash_access  = 1'b1;
               result.flash_address = faddr;
               result.is_write      = 1'b1;
               result.write_data    = item.value;
               if (cfg.has_scc && addr[15:11] == SCC_ENABLE_KEY)
                  scc_en_in = (item.value[5:0] == SCC_ON_PATTERN);
               if (addr[12:11] == BANK_LOAD_KEY)
                  bank_in[page] = item.value & mask;
            end
         end
         OP_IO_READ: begin
            if (cfg.has_psg && port == PORT_PSG_READ) begin
               result.psg_access   = 1'b1;
               result.psg_register = psg_latch_ff;
            end else begin
               result.unmapped_read = 1'b1;
            end
         end
         OP_IO_WRITE: begin
            priority if (cfg.has_psg && port == PORT_PSG_LATCH) begin
               psg_latch_in = item.value[3:0];
            end else if (cfg.has_psg && port == PORT_PSG_WRITE) begin
               result.psg_access   = 1'b1;
               result.psg_register = psg_latch_ff;
               result.is_write     = 1'b1;
               result.write_data   = item.value;
            end else begin
               psg_latch_in = psg_latch_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++)
            bank_ff[i] <= BANK_W'(i);
         scc_en_ff    <= 1'b0;
         psg_latch_ff <= '0;
      end else if (advance) begin
         bank_ff      <= bank_in;
         scc_en_ff    <= scc_en_in;
         psg_latch_ff <= psg_latch_in;
      end
   end

endmodule

// File: hw/rtl/scc_flash_bank_mapper.sv
// Top level of the flash bank mapper: input register, decode core, result register.
// Depends on sfbm_pkg, sfbm_csr and sfbm_core.
//
// Each item is one CPU bus access (memory or I/O, read or write). The mapper
// tells where it goes: flash with the translated 21-bit address, the SCC
// window 0x9800-0x9FFF while enabled, the PSG on ports 0x10-0x12, or nowhere
// (reads then flag unmapped_read). One item is taken every clock cycle while the
// result side drains; it passes the input and then the result register. The rate
// is set by the core stage, which decodes the held item and updates the bank
// registers, SCC enable and PSG latch in the same cycle, so the next item
// always sees the state left by the one before. The result register holds
// a stalled result while the input register keeps taking items as long as
// the result side drains. Configuration registers are at byte addresses
// 0x0 (block_count_log2), 0x4 (has_scc), 0x8 (has_psg) and are to be
// written only with no items in flight.
module scc_flash_bank_mapper import sfbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type core_result;
   logic    advance;      // held item moves into the result register
   logic    take;         // new item accepted

   sfbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfbm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (in_item_ff),
      .result  (core_result)
   );

   // result register frees up when empty or when its item is taken
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign take      = req_valid & req_ready;

   assign in_valid_in  = take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take)
         in_item_ff <= req_data;
      if (advance)
         out_item_ff <= core_result;
   end

endmodule

// File: hw/rtl/sfbm_checker.sv
// Port-level checks for the flash bank mapper, bound to the top level.
// Depends on sfbm_pkg and scc_flash_bank_mapper.
module sfbm_checker import sfbm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // no result right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // unmapped reads route nowhere
   a_unmapped_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unmapped_read |->
         !rsp_data.flash_access && !rsp_data.scc_access &&
         !rsp_data.psg_access && !rsp_data.is_write)
      else $error("unmapped read also routed");

   // flash address, write data and PSG register stay zero unless used
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.flash_access || rsp_data.flash_address == '0) &&
         (rsp_data.is_write || rsp_data.write_data == '0) &&
         (rsp_data.psg_access || rsp_data.psg_register == '0))
      else $error("field set without its access flag");

   // at most one target on reads, only writes reach two
   a_single_target_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_write |->
         $countones({rsp_data.flash_access, rsp_data.scc_access,
                     rsp_data.psg_access, rsp_data.unmapped_read}) <= 1)
      else $error("read routed to more than one target");

endmodule

bind scc_flash_bank_mapper sfbm_checker u_sfbm_checker (.*);
